FILE: rtl/prime_bitmap_gap_encoder_core_defines.svh
// assertion macros for the gap encoder rtl
`ifndef PRIME_BITMAP_GAP_ENCODER_CORE_DEFINES_SVH
`define PRIME_BITMAP_GAP_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every clock outside reset
`define PBGE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define PBGE_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PBGE_ASSERT(label, prop, msg)
`define PBGE_NEVER(label, cond, msg)

`endif

`endif

FILE: rtl/pbge_pkg.sv
package pbge_pkg;

    // widths of the word counter, primes and the prime index
    localparam int WORD_INDEX_BITS = 24;
    localparam int PRIME_W         = 31;
    localparam int GAP_W           = 8;
    localparam int CNT_W           = 27;
    localparam int MASK_W          = 32;
    localparam int BIT_IDX_W       = 5;
    localparam int OFFSET_W        = 7;

    // work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // largest gap code that fits the output field
    localparam logic [PRIME_W-1:0] GAP_MAX = PRIME_W'((1 << GAP_W) - 1);

    // wheel residues mod 12
    localparam logic [3:0] RESIDUE_1  = 4'd1;
    localparam logic [3:0] RESIDUE_5  = 4'd5;
    localparam logic [3:0] RESIDUE_7  = 4'd7;
    localparam logic [3:0] RESIDUE_11 = 4'd11;

    // position of each residue inside one bitmap bit group
    localparam logic [1:0] SLOT_RES1  = 2'd0;
    localparam logic [1:0] SLOT_RES5  = 2'd1;
    localparam logic [1:0] SLOT_RES7  = 2'd2;
    localparam logic [1:0] SLOT_RES11 = 2'd3;

    // one queued word: mask in bit-major order, bit 4*b+slot
    typedef struct packed {
        logic                restart;
        logic [MASK_W-1:0]   mask;
        logic [PRIME_W-1:0]  base;
    } pbge_entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } pbge_queue_status_t;

    // offset of a mask bit from the word base: 12*b + residue
    function automatic logic [OFFSET_W-1:0] bit_offset(input logic [BIT_IDX_W-1:0] idx);
        logic [2:0]          blk;
        logic [3:0]          res;
        logic [OFFSET_W-1:0] off;
        blk = idx[BIT_IDX_W-1:2];
        case (idx[1:0])
            SLOT_RES1:  res = RESIDUE_1;
            SLOT_RES5:  res = RESIDUE_5;
            SLOT_RES7:  res = RESIDUE_7;
            SLOT_RES11: res = RESIDUE_11;
            default:    res = RESIDUE_1;
        endcase
        off = OFFSET_W'({blk, 3'b000}) + OFFSET_W'({blk, 2'b00}) + OFFSET_W'(res);
        return off;
    endfunction

endpackage

FILE: rtl/pbge_queue.sv
module pbge_queue
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  pbge_pkg::pbge_entry_t       push_entry,
    input  logic                        pop,
    output pbge_pkg::pbge_entry_t       pop_entry,
    output pbge_pkg::pbge_queue_status_t status
);
    import pbge_pkg::*;

    pbge_entry_t            entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;

    // status flags
    assign status.full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/pbge_front.sv
module pbge_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    input  logic [7:0]                    mask_res1,
    input  logic [7:0]                    mask_res5,
    input  logic [7:0]                    mask_res7,
    input  logic [7:0]                    mask_res11,
    input  pbge_pkg::pbge_queue_status_t  status,
    output logic                          push,
    output pbge_pkg::pbge_entry_t         push_entry
);
    import pbge_pkg::*;

    localparam int BASE_WIDE_W = WORD_INDEX_BITS + PRIME_W;

    logic [WORD_INDEX_BITS-1:0] word_reg;
    logic [WORD_INDEX_BITS-1:0] word_next;
    logic [WORD_INDEX_BITS-1:0] word_cur;
    logic [BASE_WIDE_W-1:0]     word_wide;
    logic [BASE_WIDE_W-1:0]     base_wide;
    logic [MASK_W-1:0]          mask_merged;

    // accept whenever the queue has room
    assign in_stall = status.full;
    assign push     = in_valid && !status.full;

    // word position with restart applied first
    assign word_cur  = restart ? '0 : word_reg;
    assign word_next = push ? word_cur + WORD_INDEX_BITS'(1) : word_reg;

    // base = 96*k, kept modulo 2^31
    assign word_wide = BASE_WIDE_W'(word_cur);
    assign base_wide = (word_wide << 6) + (word_wide << 5);

    // interleave the four residue bytes into scan order
    always_comb
    begin
        mask_merged = '0;
        for (int b = 0; b < 8; b++)
        begin
            mask_merged[4*b + 0] = mask_res1[b];
            mask_merged[4*b + 1] = mask_res5[b];
            mask_merged[4*b + 2] = mask_res7[b];
            mask_merged[4*b + 3] = mask_res11[b];
        end
    end

    assign push_entry.restart = restart;
    assign push_entry.mask    = mask_merged;
    assign push_entry.base    = base_wide[PRIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: rtl/pbge_back.sv
`include "prime_bitmap_gap_encoder_core_defines.svh"

module pbge_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         halve_gaps,
    input  pbge_pkg::pbge_queue_status_t status,
    input  pbge_pkg::pbge_entry_t        pop_entry,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pbge_pkg::PRIME_W-1:0] prime_value,
    output logic [pbge_pkg::GAP_W-1:0]   gap_code,
    output logic                         gap_overflow,
    output logic [pbge_pkg::CNT_W-1:0]   prime_index,
    output logic                         last_of_item
);
    import pbge_pkg::*;

    logic [MASK_W-1:0]    mask_reg;
    logic [MASK_W-1:0]    mask_next;
    logic [PRIME_W-1:0]   base_reg;
    logic [PRIME_W-1:0]   base_next;
    logic [PRIME_W-1:0]   prev_reg;
    logic [PRIME_W-1:0]   prev_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [PRIME_W-1:0]   prime_reg;
    logic [GAP_W-1:0]     gap_reg;
    logic                 over_reg;
    logic [CNT_W-1:0]     index_reg;
    logic                 last_reg;

    logic                 slot_free;
    logic                 emit;
    logic [MASK_W-1:0]    lowest;
    logic [MASK_W-1:0]    mask_after;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic [PRIME_W-1:0]   prime;
    logic [PRIME_W-1:0]   gap;
    logic [PRIME_W-1:0]   code;
    logic                 over;
    logic                 item_done;
    logic                 restart_load;

    // one prime per cycle while the output slot can take it
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = (mask_reg != '0) && slot_free;

    // lowest pending bit of the current word
    assign lowest = mask_reg & (~mask_reg + MASK_W'(1));

    always_comb
    begin
        bit_idx = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (lowest[i])
            begin
                bit_idx = bit_idx | BIT_IDX_W'(i);
            end
        end
    end

    assign mask_after = emit ? (mask_reg & ~lowest) : mask_reg;
    assign item_done  = (mask_after == '0);

    // prime, gap and saturation
    assign prime = base_reg + PRIME_W'(bit_offset(bit_idx));
    assign gap   = prime - prev_reg;
    assign code  = halve_gaps ? (gap >> 1) : gap;
    assign over  = (code > GAP_MAX);

    // next word is taken as soon as the current one runs dry
    assign pop          = !status.empty && item_done;
    assign restart_load = pop && pop_entry.restart;

    always_comb
    begin
        mask_next  = pop ? pop_entry.mask : mask_after;
        base_next  = pop ? pop_entry.base : base_reg;
        prev_next  = emit ? prime : prev_reg;
        count_next = emit ? count_reg + CNT_W'(1) : count_reg;
        if (restart_load)
        begin
            prev_next  = '0;
            count_next = '0;
        end
        out_valid_next = slot_free ? emit : out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            prev_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            prev_reg      <= prev_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        if (emit)
        begin
            prime_reg <= prime;
            gap_reg   <= over ? GAP_W'(GAP_MAX) : code[GAP_W-1:0];
            over_reg  <= over;
            index_reg <= count_reg;
            last_reg  <= item_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign prime_value  = prime_reg;
    assign gap_code     = gap_reg;
    assign gap_overflow = over_reg;
    assign prime_index  = index_reg;
    assign last_of_item = last_reg;

    // checks
    `PBGE_NEVER(a_pop_empty, pop && status.empty, "pop from empty queue")
    `PBGE_ASSERT(a_more_bits, (emit && !item_done) |=> (mask_reg != '0),
        "word dropped with bits pending")
    `PBGE_ASSERT(a_prev_track, (emit && !restart_load) |=> (prev_reg == prime_value),
        "previous prime not tracking output")
    `PBGE_ASSERT(a_count_step, (emit && !restart_load) |=>
        (count_reg == $past(count_reg) + CNT_W'(1)), "prime counter did not step")

endmodule

FILE: rtl/prime_bitmap_gap_encoder_core.sv
// channel   dir  handshake            payload
// input     in   in_valid / in_stall  restart, mask_res1, mask_res5, mask_res7, mask_res11
// output    out  out_valid/ out_stall prime_value, gap_code, gap_overflow, prime_index,
//                                     last_of_item
// config    in   cfg_we               cfg_data -> halve_gaps
//
// the back end emits one prime per cycle while out_stall is low; an item yields one
// prime per set bit, from the single-bit serializer
// a four-entry queue lets the front accept one item per cycle until it fills
// reset clears word position, previous prime, prime index and halve_gaps
// out_stall holds the output register and stops the serializer; in_stall is
// high only while the queue is full
module prime_bitmap_gap_encoder_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         restart,
    input  logic [7:0]                   mask_res1,
    input  logic [7:0]                   mask_res5,
    input  logic [7:0]                   mask_res7,
    input  logic [7:0]                   mask_res11,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pbge_pkg::PRIME_W-1:0] prime_value,
    output logic [pbge_pkg::GAP_W-1:0]   gap_code,
    output logic                         gap_overflow,
    output logic [pbge_pkg::CNT_W-1:0]   prime_index,
    output logic                         last_of_item
);
    import pbge_pkg::*;

    logic               halve_reg;
    logic               push;
    logic               pop;
    pbge_entry_t        push_entry;
    pbge_entry_t        pop_entry;
    pbge_queue_status_t status;

    // gap mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halve_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            halve_reg <= cfg_data;
        end
    end

    pbge_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .mask_res1  (mask_res1),
        .mask_res5  (mask_res5),
        .mask_res7  (mask_res7),
        .mask_res11 (mask_res11),
        .status     (status),
        .push       (push),
        .push_entry (push_entry)
    );

    pbge_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (status)
    );

    pbge_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .halve_gaps   (halve_reg),
        .status       (status),
        .pop_entry    (pop_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .prime_value  (prime_value),
        .gap_code     (gap_code),
        .gap_overflow (gap_overflow),
        .prime_index  (prime_index),
        .last_of_item (last_of_item)
    );

endmodule

FILE: tb/sv/tb_prime_bitmap_gap_encoder_core.sv
`timescale 1ns / 100ps

module tb_prime_bitmap_gap_encoder_core;
    import pbge_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 24;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int TIMEOUT_NS      = 8_000_000;
    localparam int N_ROWS          = 25;

    // one prime as it leaves the block
    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic [GAP_W-1:0]   gap;
        logic               ovf;
        logic [CNT_W-1:0]   index;
        logic               last;
    } prime_entry_t;

    // directed row: either a halve_gaps write or one bitmap word
    typedef struct packed {
        logic         cfg_wr;
        logic         cfg_val;
        logic         rs;
        logic [7:0]   m1;
        logic [7:0]   m5;
        logic [7:0]   m7;
        logic [7:0]   m11;
        logic         typed;
        prime_entry_t want;
    } stim_row_t;

    localparam prime_entry_t NO_WANT = '0;

    // typed rows produce exactly one prime whose fields are known by hand
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // full gaps
        '{1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        // first prime after restart: gap is the prime itself
        '{1'b0, 1'b0, 1'b1, 8'h00, 8'h01, 8'h00, 8'h00, 1'b1,
          '{31'd5, 8'd5, 1'b0, 27'd0, 1'b1}},
        // empty word still advances the position
        '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        // densest word, 32 primes
        '{1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b1, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1,
          '{31'd85, 8'd85, 1'b0, 27'd0, 1'b1}},
        '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h80, 1'b1,
          '{31'd191, 8'd106, 1'b0, 27'd1, 1'b1}},
        '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        // gap above 255 saturates
        '{1'b0, 1'b0, 1'b0, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1,
          '{31'd469, 8'd255, 1'b1, 27'd2, 1'b1}},
        '{1'b0, 1'b0, 1'b0, 8'h01, 8'h02, 8'h04, 8'h08, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b0, 8'hAA, 8'h55, 8'h0F, 8'hF0, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b1, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1,
          '{31'd1, 8'd1, 1'b0, 27'd0, 1'b1}},
        // halved gaps
        '{1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h01, 8'h00, 1'b1,
          '{31'd7, 8'd3, 1'b0, 27'd0, 1'b1}},
        '{1'b0, 1'b0, 1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1,
          '{31'd97, 8'd45, 1'b0, 27'd1, 1'b1}},
        '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        // halved gap still above 255
        '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h80, 1'b1,
          '{31'd671, 8'd255, 1'b1, 27'd2, 1'b1}},
        '{1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h01, 1'b1,
          '{31'd11, 8'd5, 1'b0, 27'd0, 1'b1}},
        // back to full gaps
        '{1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT}
    };

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic               cfg_data   = 1'b0;
    logic               in_valid   = 1'b0;
    logic               restart    = 1'b0;
    logic [7:0]         mask_res1  = 8'h00;
    logic [7:0]         mask_res5  = 8'h00;
    logic [7:0]         mask_res7  = 8'h00;
    logic [7:0]         mask_res11 = 8'h00;
    logic               out_stall  = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [PRIME_W-1:0] prime_value;
    logic [GAP_W-1:0]   gap_code;
    logic               gap_overflow;
    logic [CNT_W-1:0]   prime_index;
    logic               last_of_item;

    // gap list state mirrored from the block
    logic                       halve_mode  = 1'b0;
    logic [WORD_INDEX_BITS-1:0] word_pos    = '0;
    logic [PRIME_W-1:0]         last_prime  = '0;
    logic [CNT_W-1:0]           prime_count = '0;

    prime_entry_t pending_primes [$];
    prime_entry_t word_primes [32];
    prime_entry_t got_prime;
    prime_entry_t want_prime;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int empty_run      = 0;

    prime_bitmap_gap_encoder_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .mask_res1    (mask_res1),
        .mask_res5    (mask_res5),
        .mask_res7    (mask_res7),
        .mask_res11   (mask_res11),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .prime_value  (prime_value),
        .gap_code     (gap_code),
        .gap_overflow (gap_overflow),
        .prime_index  (prime_index),
        .last_of_item (last_of_item)
    );

    // clock
    always #(CLK_HALF) clk = ~clk;

    // expands one bitmap word into primes, fills word_primes, returns the count
    function automatic int expand_word(input logic rs, input logic [7:0] m1,
                                       input logic [7:0] m5, input logic [7:0] m7,
                                       input logic [7:0] m11);
        logic [3:0]         residue [4];
        logic [7:0]         lanes [4];
        logic [39:0]        base;
        logic [PRIME_W-1:0] prime;
        logic [PRIME_W-1:0] gap;
        logic [PRIME_W-1:0] code;
        int                 n;
        residue[0] = RESIDUE_1;
        residue[1] = RESIDUE_5;
        residue[2] = RESIDUE_7;
        residue[3] = RESIDUE_11;
        lanes[0]   = m1;
        lanes[1]   = m5;
        lanes[2]   = m7;
        lanes[3]   = m11;
        n          = 0;
        if (rs)
        begin
            word_pos    = '0;
            last_prime  = '0;
            prime_count = '0;
        end
        // bit-major walk, residues in wheel order within a bit
        for (int b = 0; b < 8; b++)
        begin
            base = 40'd12 * (40'd8 * 40'(word_pos) + 40'(b));
            for (int r = 0; r < 4; r++)
            begin
                if (lanes[r][b])
                begin
                    prime = PRIME_W'(base + 40'(residue[r]));
                    gap   = prime - last_prime;
                    code  = halve_mode ? (gap >> 1) : gap;
                    word_primes[n].prime = prime;
                    word_primes[n].gap   = (code > GAP_MAX) ? GAP_W'(GAP_MAX) : GAP_W'(code);
                    word_primes[n].ovf   = (code > GAP_MAX);
                    word_primes[n].index = prime_count;
                    word_primes[n].last  = 1'b0;
                    prime_count = prime_count + 1'b1;
                    last_prime  = prime;
                    n++;
                end
            end
        end
        if (n > 0)
            word_primes[n-1].last = 1'b1;
        word_pos = word_pos + 1'b1;
        return n;
    endfunction

    // drives one word and waits for its transaction, entered at a falling edge
    task automatic send_word(input logic rs, input logic [7:0] m1, input logic [7:0] m5,
                             input logic [7:0] m7, input logic [7:0] m11,
                             input logic typed, input prime_entry_t want);
        int n;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid   = 1'b1;
        restart    = rs;
        mask_res1  = m1;
        mask_res5  = m5;
        mask_res7  = m7;
        mask_res11 = m11;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = expand_word(rs, m1, m5, m7, m11);
        if (typed)
            pending_primes = {pending_primes, want};
        else
            for (int i = 0; i < n; i++)
                pending_primes = {pending_primes, word_primes[i]};
        @(negedge clk);
    endtask

    // sender holds off until every prime is out and the pipeline is empty
    task automatic settle();
        in_valid = 1'b0;
        while (pending_primes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // halve_gaps write while the block is idle
    task automatic write_halve(input logic value);
        settle();
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we     = 1'b0;
        halve_mode = value;
    endtask

    // random word: mostly sparse, with empty runs to stretch the gaps
    task automatic send_random_word();
        logic       rs;
        logic [7:0] lanes [4];
        int         kind;
        rs = ($urandom_range(99) < 4);
        if (empty_run == 0 && $urandom_range(99) < 6)
            empty_run = $urandom_range(3, 8);
        kind = $urandom_range(99);
        for (int r = 0; r < 4; r++)
        begin
            if (empty_run > 0 || kind < 20)
                lanes[r] = 8'h00;
            else if (kind < 70)
                lanes[r] = ($urandom_range(3) == 0) ? 8'(1 << $urandom_range(7)) : 8'h00;
            else if (kind < 93)
                lanes[r] = 8'($urandom);
            else
                lanes[r] = 8'hFF;
        end
        if (empty_run > 0)
        begin
            empty_run--;
            rs = 1'b0;
        end
        send_word(rs, lanes[0], lanes[1], lanes[2], lanes[3], 1'b0, NO_WANT);
    endtask

    task automatic run_phase(input logic halve, input int idle_pct, input int stall_pct,
                             input int count);
        write_halve(halve);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_word();
    endtask

    // receiver stall, changed at the falling edge
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // compare each output transaction with the oldest expected prime
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_prime = '{prime_value, gap_code, gap_overflow, prime_index, last_of_item};
            if (pending_primes.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected prime %0d gap %0d ovf %0b index %0d last %0b",
                         $time, prime_value, gap_code, gap_overflow, prime_index,
                         last_of_item);
            end
            else
            begin
                want_prime = pending_primes.pop_front();
                if (got_prime !== want_prime)
                begin
                    error_count++;
                    $display("%0t mismatch expected prime %0d gap %0d ovf %0b index %0d last %0b",
                             $time, want_prime.prime, want_prime.gap, want_prime.ovf,
                             want_prime.index, want_prime.last);
                    $display("%0t mismatch actual   prime %0d gap %0d ovf %0b index %0d last %0b",
                             $time, got_prime.prime, got_prime.gap, got_prime.ovf,
                             got_prime.index, got_prime.last);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words under the first idling mix
        send_idle_pct  = 10;
        recv_stall_pct = 46;
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (DIRECTED_ROWS[i].cfg_wr)
                write_halve(DIRECTED_ROWS[i].cfg_val);
            else
                send_word(DIRECTED_ROWS[i].rs, DIRECTED_ROWS[i].m1, DIRECTED_ROWS[i].m5,
                          DIRECTED_ROWS[i].m7, DIRECTED_ROWS[i].m11,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        // random words under the first idling mix, then swapped, then off
        run_phase(1'b1, 10, 46, ITEMS_PER_PHASE);
        run_phase(1'b0, 46, 10, ITEMS_PER_PHASE);
        run_phase(1'b1, 0, 0, ITEMS_PER_PHASE);
        settle();

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pbge_pkg.sv
rtl/pbge_queue.sv
rtl/pbge_front.sv
rtl/pbge_back.sv
rtl/prime_bitmap_gap_encoder_core.sv
tb/sv/tb_prime_bitmap_gap_encoder_core.sv
